/* rtl/trial_division_prime_test_top_defines.svh */
// Assertion macros for the trial division prime test block.
`ifndef TRIAL_DIVISION_PRIME_TEST_TOP_DEFINES_SVH
`define TRIAL_DIVISION_PRIME_TEST_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
`define TDPT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tdpt: same-cycle check failed");
`define TDPT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tdpt: next-cycle check failed");
`else
`define TDPT_ASSERT_IMP(lbl, ante, cons)
`define TDPT_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

/* rtl/tdpt_pkg.sv */
// Package: types and constants of the trial division prime test block.
`default_nettype none
package tdpt_pkg;

  localparam int IN_WIDTH            = 32;
  localparam int VALUE_WIDTH_DEFAULT = 32;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TEST,
    ST_WAIT,
    ST_FINISH
  } tdpt_state_t;

  typedef struct packed {
    logic done;
    logic rem_zero;
  } tdpt_div_stat_t;

endpackage
`default_nettype wire

/* rtl/tdpt_if.sv */
// Interfaces: input value channel and result channel.
`default_nettype none
interface tdpt_in_if;
  import tdpt_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [IN_WIDTH-1:0] number;
  modport source (output valid, output number, input ready);
  modport sink (input valid, input number, output ready);
endinterface

interface tdpt_out_if;
  logic valid;
  logic ready;
  logic is_prime;
  modport source (output valid, output is_prime, input ready);
  modport sink (input valid, input is_prime, output ready);
endinterface
`default_nettype wire

/* rtl/tdpt_rem_serial.sv */
// Bit-serial restoring remainder unit: one dividend bit per cycle.
`default_nettype none
module tdpt_rem_serial #(
  parameter int MAG_WIDTH = tdpt_pkg::VALUE_WIDTH_DEFAULT - 1
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [MAG_WIDTH-1:0]  dividend,
  input  wire logic [MAG_WIDTH-1:0]  divisor,
  output tdpt_pkg::tdpt_div_stat_t   stat
);
  import tdpt_pkg::*;

  localparam int CNT_W = $clog2(MAG_WIDTH);

  logic                 busy;
  logic                 done;
  logic [CNT_W-1:0]     cnt;
  logic [MAG_WIDTH-1:0] shreg;
  logic [MAG_WIDTH-1:0] rem;
  logic [MAG_WIDTH-1:0] rem_next;
  logic [MAG_WIDTH:0]   trial;
  logic [MAG_WIDTH:0]   dvs_ext;

  always_comb begin
    trial   = {rem, shreg[MAG_WIDTH-1]};
    dvs_ext = {1'b0, divisor};
    if (trial >= dvs_ext) begin
      rem_next = MAG_WIDTH'(trial - dvs_ext);
    end else begin
      rem_next = trial[MAG_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= CNT_W'(MAG_WIDTH - 1);
        shreg <= dividend;
        rem   <= '0;
      end else if (busy) begin
        rem   <= rem_next;
        shreg <= shreg << 1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  assign stat.done     = done;
  assign stat.rem_zero = (rem == '0);

endmodule
`default_nettype wire

/* rtl/trial_division_prime_test_top.sv */
// Flow: values below 2 go straight from acceptance to the finish state; otherwise each
// divisor tried runs a bit-serial remainder over VALUE_WIDTH-1 bits plus a test and a
// check, for up to about sqrt(value) - 1 divisors.
// Throughput: one value at a time; the next value is accepted while a result word waits.
// The serial remainder unit sets the pace of each test.
// Reset: synchronous active-high rst clears the controller state, the result valid flag and the unit's busy and done.
`default_nettype none
`include "trial_division_prime_test_top_defines.svh"
module trial_division_prime_test_top #(
  parameter int VALUE_WIDTH = tdpt_pkg::VALUE_WIDTH_DEFAULT
) (
  input wire logic   clk,
  input wire logic   rst,
  tdpt_in_if.sink    req,
  tdpt_out_if.source rsp
);
  import tdpt_pkg::*;

  localparam int M  = VALUE_WIDTH - 1;
  localparam int CW = (VALUE_WIDTH < IN_WIDTH) ? VALUE_WIDTH : IN_WIDTH;

  tdpt_state_t      state, state_next;
  logic [M-1:0]     mag, mag_next;
  logic [M-1:0]     d, d_next;
  logic [M:0]       sq, sq_next;
  logic             res, res_next;
  logic             out_valid;
  logic             out_bit;
  logic             out_load;
  logic             div_start;
  logic             acc_in;
  logic             in_neg;
  logic [VALUE_WIDTH-1:0] in_val;
  tdpt_div_stat_t   div_stat;

  assign in_val = VALUE_WIDTH'(req.number[CW-1:0]);
  assign in_neg = in_val[VALUE_WIDTH-1];
  assign acc_in = req.valid && req.ready;

  assign req.ready    = (state == ST_IDLE);
  assign rsp.valid    = out_valid;
  assign rsp.is_prime = out_bit;

  tdpt_rem_serial #(
    .MAG_WIDTH(M)
  ) u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (mag),
    .divisor  (d),
    .stat     (div_stat)
  );

  always_comb begin
    state_next = state;
    mag_next   = mag;
    d_next     = d;
    sq_next    = sq;
    res_next   = res;
    div_start  = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (acc_in) begin
          mag_next = in_val[M-1:0];
          d_next   = M'(2);
          sq_next  = (M + 1)'(4);
          if (in_neg || (in_val[M-1:1] == '0)) begin
            res_next   = 1'b0;
            state_next = ST_FINISH;
          end else begin
            state_next = ST_TEST;
          end
        end
      end
      ST_TEST: begin
        if (sq > {1'b0, mag}) begin
          res_next   = 1'b1;
          state_next = ST_FINISH;
        end else begin
          div_start  = 1'b1;
          state_next = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (div_stat.done) begin
          if (div_stat.rem_zero) begin
            res_next   = 1'b0;
            state_next = ST_FINISH;
          end else begin
            // (d+1)^2 = d^2 + 2d + 1
            d_next     = d + 1'b1;
            sq_next    = sq + {d, 1'b1};
            state_next = ST_TEST;
          end
        end
      end
      ST_FINISH: begin
        // hold until the result word is free or being taken
        if (!out_valid || rsp.ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    mag <= mag_next;
    d   <= d_next;
    sq  <= sq_next;
    res <= res_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_bit <= res;
    end
  end

  `TDPT_ASSERT_NXT(a_start_waits, div_start, state == ST_WAIT)
  `TDPT_ASSERT_IMP(a_square_track, state == ST_TEST, sq == VALUE_WIDTH'(d) * VALUE_WIDTH'(d))
  `TDPT_ASSERT_NXT(a_neg_rejected, acc_in && in_neg, (state == ST_FINISH) && !res)

endmodule
`default_nettype wire
